// ----- rtl/mvna_pkg.sv -----
// Shared types and constants of the mesh vertex normal accumulator.
// Used by every module of the block; depends on nothing.

package mvna_pkg;

  localparam int MAX_POINTS = 65536;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int IDX_W      = 16;
  localparam int COORD_W    = 24;
  localparam int SUM_W      = 24;
  localparam int NORM_W     = 16;
  localparam int VEC_W      = 2 * (COORD_W + 1) + 2;
  localparam int ONE_Q14    = 16384;
  localparam int Q_DEPTH    = 2;
  localparam int QPTR_W     = 1;

  typedef enum logic [1:0] {
    OP_WRITE_POINT  = 2'd0,
    OP_ADD_TRIANGLE = 2'd1,
    OP_READ_NORMAL  = 2'd2,
    OP_UNUSED       = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic                       idx_ok;
    logic [ADDR_W-1:0]          a;
    logic [ADDR_W-1:0]          b;
    logic [ADDR_W-1:0]          c;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [COORD_W-1:0]  z;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic                     start;
    logic signed [VEC_W-1:0]  vx;
    logic signed [VEC_W-1:0]  vy;
    logic signed [VEC_W-1:0]  vz;
  } unit_req_t;

  typedef struct packed {
    logic                      done;
    logic                      zero;
    logic signed [NORM_W-1:0]  nx;
    logic signed [NORM_W-1:0]  ny;
    logic signed [NORM_W-1:0]  nz;
  } unit_rsp_t;

endpackage

// ----- rtl/mesh_vertex_normal_accumulator.sv -----
// Top level of the mesh vertex normal accumulator: command queue, execution
// back end and shared normalizing unit. Depends on mvna_pkg and all modules.
//
//   channel   handshake          payload
//   command   start / busy       operation, vertex_a/b/c, coord_x/y/z
//   result    done (1 cycle)     normal_x/y/z, zero_sum
//
// write_point is stored as the back end pops it. add_triangle holds the back
// end through the point reads, cross product and normalizing unit, and read_normal
// through the sum read and normalizing unit; a degenerate face or a zero sum
// ends the unit early. The unit scales one bit per cycle, then runs a
// bit-serial square root and three restoring divides, one per component.
// A two-entry queue lets commands wait ahead of the back end.
// After reset a clearing pass zeroes all 65536 sum entries, one per cycle,
// with busy high. The result receiver cannot stall.

module mesh_vertex_normal_accumulator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_a,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_b,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_c,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_x,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_y,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_z,
  output logic                                done,
  output logic signed [mvna_pkg::NORM_W-1:0]  normal_x,
  output logic signed [mvna_pkg::NORM_W-1:0]  normal_y,
  output logic signed [mvna_pkg::NORM_W-1:0]  normal_z,
  output logic                                zero_sum
);

  mvna_pkg::head_t      head;
  mvna_pkg::back_stat_t bstat;
  mvna_pkg::unit_req_t  ureq;
  mvna_pkg::unit_rsp_t  ursp;

  mvna_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .vertex_a  (vertex_a),
    .vertex_b  (vertex_b),
    .vertex_c  (vertex_c),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .bstat     (bstat),
    .head      (head)
  );

  mvna_unit u_unit (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

  mvna_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .bstat    (bstat),
    .ureq     (ureq),
    .ursp     (ursp),
    .done     (done),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .zero_sum (zero_sum)
  );

endmodule

// ----- rtl/mvna_front.sv -----
// Command intake: accepts transactions, drops those that do nothing and
// queues the rest for the back end. Depends on mvna_pkg.

module mvna_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          operation,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_a,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_b,
  input  logic [mvna_pkg::IDX_W-1:0]          vertex_c,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_x,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_y,
  input  logic signed [mvna_pkg::COORD_W-1:0] coord_z,
  input  mvna_pkg::back_stat_t                bstat,
  output mvna_pkg::head_t                     head
);

  mvna_pkg::cmd_t            q [mvna_pkg::Q_DEPTH];
  logic [mvna_pkg::QPTR_W-1:0] wr_ptr;
  logic [mvna_pkg::QPTR_W-1:0] rd_ptr;
  logic [mvna_pkg::QPTR_W:0]   count;
  logic                        accept;
  logic                        keep;
  logic                        push;
  logic                        a_ok;
  logic                        b_ok;
  logic                        c_ok;
  logic [31:0]                 a32;
  logic [31:0]                 b32;
  logic [31:0]                 c32;
  mvna_pkg::op_t               op;
  mvna_pkg::cmd_t              cmd_in;

  assign busy   = bstat.clearing || (count == (mvna_pkg::QPTR_W+1)'(mvna_pkg::Q_DEPTH));
  assign accept = start && !busy;
  assign op     = mvna_pkg::op_t'(operation);
  assign a32    = 32'(vertex_a);
  assign b32    = 32'(vertex_b);
  assign c32    = 32'(vertex_c);
  assign a_ok   = a32 < 32'(mvna_pkg::MAX_POINTS);
  assign b_ok   = b32 < 32'(mvna_pkg::MAX_POINTS);
  assign c_ok   = c32 < 32'(mvna_pkg::MAX_POINTS);

  // Out-of-range writes and triangles are dropped here; a read out of range
  // still answers, so it travels with its flag.
  always_comb begin
    case (op)
      mvna_pkg::OP_WRITE_POINT:  keep = a_ok;
      mvna_pkg::OP_ADD_TRIANGLE: keep = a_ok && b_ok && c_ok;
      mvna_pkg::OP_READ_NORMAL:  keep = 1'b1;
      default:                   keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

  always_comb begin
    cmd_in.op     = op;
    cmd_in.idx_ok = a_ok;
    cmd_in.a      = a32[mvna_pkg::ADDR_W-1:0];
    cmd_in.b      = b32[mvna_pkg::ADDR_W-1:0];
    cmd_in.c      = c32[mvna_pkg::ADDR_W-1:0];
    cmd_in.x      = coord_x;
    cmd_in.y      = coord_y;
    cmd_in.z      = coord_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (bstat.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !bstat.pop) begin
        count <= count + 1'b1;
      end else if (!push && bstat.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (mvna_pkg::QPTR_W+1)'(mvna_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    bstat.pop |-> count != '0)
    else $error("pop from empty queue");

  a_push_seen: assert property (@(posedge clk) disable iff (rst)
    (push && count == '0) |=> head.valid)
    else $error("pushed transaction not visible at head");

endmodule

// ----- rtl/mvna_unit.sv -----
// Shared normalizing unit: scales a vector to unit length in Q1.14 with a
// bit-serial square root and restoring divides. Depends on mvna_pkg.

module mvna_unit (
  input  logic                clk,
  input  logic                rst,
  input  mvna_pkg::unit_req_t req,
  output mvna_pkg::unit_rsp_t rsp
);

  localparam int MW = mvna_pkg::VEC_W;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_SQRT,
    U_DIV
  } ustate_t;

  ustate_t                          state;
  logic [MW-1:0]                    mag [3];
  logic                             neg [3];
  logic [MW-1:0]                    top;
  logic [61:0]                      acc;
  logic [59:0]                      sq;
  logic [61:0]                      rad;
  logic [62:0]                      root;
  logic [62:0]                      bitw;
  logic [31:0]                      dvs;
  logic [31:0]                      rem;
  logic [13:0]                      quo;
  logic [1:0]                       k;
  logic [3:0]                       cnt;
  logic signed [mvna_pkg::NORM_W-1:0] res [3];
  logic                             zero;
  logic                             done;

  logic signed [MW-1:0] in_v [3];
  logic [MW-1:0]        in_mag [3];
  logic [MW-1:0]        in_top;
  logic [29:0]          sq_sel;
  logic [62:0]          trial;
  logic                 ge_root;
  logic [62:0]          root_next;
  logic                 ge_div;
  logic [31:0]          rem_sub;
  logic [14:0]          q_full;
  logic [14:0]          q_cap;
  logic [15:0]          q_pos;
  logic [15:0]          q_out;
  logic [MW-1:0]        next_mag;

  always_comb begin
    in_v[0] = req.vx;
    in_v[1] = req.vy;
    in_v[2] = req.vz;
    for (int i = 0; i < 3; i++) begin
      in_mag[i] = in_v[i][MW-1] ? MW'(-in_v[i]) : MW'(in_v[i]);
    end
    in_top = (in_mag[0] > in_mag[1]) ? in_mag[0] : in_mag[1];
    if (in_mag[2] > in_top) begin
      in_top = in_mag[2];
    end
  end

  always_comb begin
    case (cnt)
      4'd0:    sq_sel = mag[0][29:0];
      4'd1:    sq_sel = mag[1][29:0];
      default: sq_sel = mag[2][29:0];
    endcase
    case (k)
      2'd0:    next_mag = mag[1];
      default: next_mag = mag[2];
    endcase
  end

  assign trial     = root + bitw;
  assign ge_root   = {1'b0, rad} >= trial;
  assign root_next = ge_root ? ((root >> 1) + bitw) : (root >> 1);

  assign ge_div  = rem >= dvs;
  assign rem_sub = ge_div ? (rem - dvs) : rem;
  assign q_full  = {quo, ge_div};
  assign q_cap   = (q_full > 15'(mvna_pkg::ONE_Q14)) ? 15'(mvna_pkg::ONE_Q14) : q_full;
  assign q_pos   = {1'b0, q_cap};
  assign q_out   = neg[k] ? (16'd0 - q_pos) : q_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        U_IDLE: begin
          if (req.start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= in_mag[i];
              neg[i] <= in_v[i][MW-1];
            end
            top   <= in_top;
            state <= U_SHIFT;
          end
        end
        U_SHIFT: begin
          // One bit a cycle until the largest magnitude sits in [2^29, 2^30).
          if (top == '0) begin
            zero  <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              res[i] <= '0;
            end
            done  <= 1'b1;
            state <= U_IDLE;
          end else if (top >= (MW'(1) << 30)) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
            top <= top >> 1;
          end else if (top < (MW'(1) << 29)) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
            top <= top << 1;
          end else begin
            acc   <= '0;
            cnt   <= '0;
            state <= U_SQ;
          end
        end
        U_SQ: begin
          if (cnt == 4'd3) begin
            rad   <= acc + 62'(sq);
            root  <= '0;
            bitw  <= 63'(1) << 62;
            state <= U_SQRT;
          end else begin
            if (cnt != 4'd0) begin
              acc <= acc + 62'(sq);
            end
            sq <= 60'(sq_sel) * 60'(sq_sel);
          end
          cnt <= cnt + 1'b1;
        end
        U_SQRT: begin
          if (ge_root) begin
            rad <= rad - trial[61:0];
          end
          root <= root_next;
          bitw <= bitw >> 2;
          if (bitw[0]) begin
            dvs   <= root_next[31:0];
            rem   <= mag[0][31:0];
            quo   <= '0;
            cnt   <= '0;
            k     <= '0;
            zero  <= 1'b0;
            state <= U_DIV;
          end
        end
        U_DIV: begin
          if (cnt == 4'd14) begin
            res[k] <= q_out;
            cnt    <= '0;
            quo    <= '0;
            if (k == 2'd2) begin
              done  <= 1'b1;
              state <= U_IDLE;
            end else begin
              k   <= k + 1'b1;
              rem <= next_mag[31:0];
            end
          end else begin
            rem <= {rem_sub[30:0], 1'b0};
            quo <= q_full[13:0];
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.zero = zero;
  assign rsp.nx   = res[0];
  assign rsp.ny   = res[1];
  assign rsp.nz   = res[2];

endmodule

// ----- rtl/mvna_back.sv -----
// Execution side: point and sum memories, cross product and the sequencer
// that drives the normalizing unit. Depends on mvna_pkg.

module mvna_back (
  input  logic                               clk,
  input  logic                               rst,
  input  mvna_pkg::head_t                    head,
  output mvna_pkg::back_stat_t               bstat,
  output mvna_pkg::unit_req_t                ureq,
  input  mvna_pkg::unit_rsp_t                ursp,
  output logic                               done,
  output logic signed [mvna_pkg::NORM_W-1:0] normal_x,
  output logic signed [mvna_pkg::NORM_W-1:0] normal_y,
  output logic signed [mvna_pkg::NORM_W-1:0] normal_z,
  output logic                               zero_sum
);

  localparam int CW = mvna_pkg::COORD_W;
  localparam int SW = mvna_pkg::SUM_W;
  localparam int AW = mvna_pkg::ADDR_W;
  localparam int VW = mvna_pkg::VEC_W;
  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;
  localparam logic signed [SW:0] SAT_HI = (SW+1)'((64'sd1 <<< (SW-1)) - 64'sd1);
  localparam logic signed [SW:0] SAT_LO = (SW+1)'(-(64'sd1 <<< (SW-1)));

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_RD_A,
    B_RD_B,
    B_RD_C,
    B_CAP_C,
    B_MUL,
    B_CROSS,
    B_NORM_T,
    B_SUM_RD,
    B_SUM_WR,
    B_RN_RD,
    B_RN_WR,
    B_NORM_R
  } bstate_t;

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] s,
                                                    input logic signed [15:0] d);
    logic signed [SW:0] t;
    t = (SW+1)'(s) + (SW+1)'(d);
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return SW'(t);
  endfunction

  bstate_t                 state;
  mvna_pkg::cmd_t          cmd;
  logic [AW-1:0]           clr;
  logic [3*CW-1:0]         pa;
  logic [3*CW-1:0]         pb;
  logic signed [EW-1:0]    e1 [3];
  logic signed [EW-1:0]    e2 [3];
  logic signed [PW-1:0]    prod [6];
  logic [2:0]              cnt;
  logic [1:0]              k;
  logic signed [15:0]      un [3];

  logic [3*CW-1:0]         pmem [mvna_pkg::MAX_POINTS];
  logic [3*CW-1:0]         p_rdata;
  logic                    p_we;
  logic [AW-1:0]           p_raddr;
  logic [3*SW-1:0]         smem [mvna_pkg::MAX_POINTS];
  logic [3*SW-1:0]         s_rdata;
  logic                    s_we;
  logic [AW-1:0]           s_waddr;
  logic [AW-1:0]           s_raddr;
  logic [3*SW-1:0]         s_wdata;
  logic [AW-1:0]           corner;

  logic signed [CW-1:0]    pa_c [3];
  logic signed [CW-1:0]    pb_c [3];
  logic signed [CW-1:0]    pr_c [3];
  logic signed [SW-1:0]    s_c [3];
  logic signed [EW-1:0]    mul_a;
  logic signed [EW-1:0]    mul_b;
  logic                    pop;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_c[i] = pa[(3-i)*CW-1 -: CW];
      pb_c[i] = pb[(3-i)*CW-1 -: CW];
      pr_c[i] = p_rdata[(3-i)*CW-1 -: CW];
      s_c[i]  = s_rdata[(3-i)*SW-1 -: SW];
    end
  end

  assign pop = (state == B_IDLE) && head.valid;
  assign bstat.pop      = pop;
  assign bstat.clearing = (state == B_CLEAR);

  always_comb begin
    case (k)
      2'd0:    corner = cmd.a;
      2'd1:    corner = cmd.b;
      default: corner = cmd.c;
    endcase
  end

  assign p_we = pop && (head.cmd.op == mvna_pkg::OP_WRITE_POINT);

  always_comb begin
    case (state)
      B_RD_A:  p_raddr = cmd.a;
      B_RD_B:  p_raddr = cmd.b;
      default: p_raddr = cmd.c;
    endcase
  end

  assign s_raddr = (state == B_SUM_RD) ? corner : cmd.a;

  always_comb begin
    case (state)
      B_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = clr;
        s_wdata = '0;
      end
      B_SUM_WR: begin
        s_we    = 1'b1;
        s_waddr = corner;
        s_wdata = {sat_add(s_c[0], un[0]), sat_add(s_c[1], un[1]), sat_add(s_c[2], un[2])};
      end
      B_RN_WR: begin
        s_we    = cmd.idx_ok;
        s_waddr = cmd.a;
        s_wdata = '0;
      end
      default: begin
        s_we    = 1'b0;
        s_waddr = cmd.a;
        s_wdata = '0;
      end
    endcase
  end

  // The six partial products of the cross product share one multiplier.
  always_comb begin
    case (cnt)
      3'd0:    begin mul_a = e1[1]; mul_b = e2[2]; end
      3'd1:    begin mul_a = e1[2]; mul_b = e2[1]; end
      3'd2:    begin mul_a = e1[2]; mul_b = e2[0]; end
      3'd3:    begin mul_a = e1[0]; mul_b = e2[2]; end
      3'd4:    begin mul_a = e1[0]; mul_b = e2[1]; end
      default: begin mul_a = e1[1]; mul_b = e2[0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[head.cmd.a] <= {head.cmd.x, head.cmd.y, head.cmd.z};
    end
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clr        <= '0;
      done       <= 1'b0;
      ureq.start <= 1'b0;
    end else begin
      done       <= 1'b0;
      ureq.start <= 1'b0;
      case (state)
        B_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == AW'(mvna_pkg::MAX_POINTS - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (head.valid) begin
            cmd <= head.cmd;
            case (head.cmd.op)
              mvna_pkg::OP_ADD_TRIANGLE: state <= B_RD_A;
              mvna_pkg::OP_READ_NORMAL:  state <= B_RN_RD;
              default:                   state <= B_IDLE;
            endcase
          end
        end
        B_RD_A: state <= B_RD_B;
        B_RD_B: begin
          pa    <= p_rdata;
          state <= B_RD_C;
        end
        B_RD_C: begin
          pb    <= p_rdata;
          state <= B_CAP_C;
        end
        B_CAP_C: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= EW'(pb_c[i]) - EW'(pa_c[i]);
            e2[i] <= EW'(pr_c[i]) - EW'(pa_c[i]);
          end
          cnt   <= '0;
          state <= B_MUL;
        end
        B_MUL: begin
          prod[cnt] <= PW'(mul_a) * PW'(mul_b);
          cnt       <= cnt + 1'b1;
          if (cnt == 3'd5) begin
            state <= B_CROSS;
          end
        end
        B_CROSS: begin
          ureq.start <= 1'b1;
          ureq.vx    <= VW'(prod[0]) - VW'(prod[1]);
          ureq.vy    <= VW'(prod[2]) - VW'(prod[3]);
          ureq.vz    <= VW'(prod[4]) - VW'(prod[5]);
          state      <= B_NORM_T;
        end
        B_NORM_T: begin
          if (ursp.done) begin
            un[0] <= ursp.nx;
            un[1] <= ursp.ny;
            un[2] <= ursp.nz;
            k     <= '0;
            // A degenerate face leaves every sum untouched.
            state <= ursp.zero ? B_IDLE : B_SUM_RD;
          end
        end
        B_SUM_RD: state <= B_SUM_WR;
        B_SUM_WR: begin
          if (k == 2'd2) begin
            state <= B_IDLE;
          end else begin
            k     <= k + 1'b1;
            state <= B_SUM_RD;
          end
        end
        B_RN_RD: state <= B_RN_WR;
        B_RN_WR: begin
          ureq.start <= 1'b1;
          ureq.vx    <= cmd.idx_ok ? VW'(s_c[0]) : '0;
          ureq.vy    <= cmd.idx_ok ? VW'(s_c[1]) : '0;
          ureq.vz    <= cmd.idx_ok ? VW'(s_c[2]) : '0;
          state      <= B_NORM_R;
        end
        B_NORM_R: begin
          if (ursp.done) begin
            done     <= 1'b1;
            normal_x <= ursp.nx;
            normal_y <= ursp.ny;
            normal_z <= ursp.nz;
            zero_sum <= ursp.zero;
            state    <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_done_from_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == B_NORM_R))
    else $error("result strobe outside a read");

  a_start_waits: assert property (@(posedge clk) disable iff (rst)
    ureq.start |-> (state == B_NORM_T || state == B_NORM_R))
    else $error("unit started without waiting for it");

  a_unit_expected: assert property (@(posedge clk) disable iff (rst)
    ursp.done |-> (state == B_NORM_T || state == B_NORM_R))
    else $error("unit finished while nobody waits");

endmodule
